// ===== sv/svie_pkg.sv =====
// Shared types and constants for the stack machine instruction executor.
// No dependencies.
package svie_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int LOCALS_MAX  = 256;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int LA_W        = $clog2(LOCALS_MAX);
    localparam int DIV_CYCLES  = 64;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_START = 2'd3;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    localparam logic CFG_LOCALS  = 1'b0;
    localparam logic CFG_PROGLEN = 1'b1;

    typedef enum logic [5:0] {
        OP_PUSH = 6'd0, OP_ADD = 6'd1, OP_SUB = 6'd2, OP_MUL = 6'd3, OP_DIV = 6'd4,
        OP_EMIT = 6'd5, OP_SWAP = 6'd9, OP_DUP = 6'd10, OP_LOAD = 6'd11,
        OP_STLOC = 6'd12, OP_IFEQ = 6'd13, OP_IFNE = 6'd14, OP_GOTO = 6'd15,
        OP_AND = 6'd16, OP_OR = 6'd17, OP_XOR = 6'd18, OP_SHL = 6'd19,
        OP_SHR = 6'd20, OP_USHR = 6'd21, OP_IFLT = 6'd22, OP_IFLE = 6'd23,
        OP_IFGT = 6'd24, OP_IFGE = 6'd25, OP_I2L = 6'd26, OP_I2B = 6'd27,
        OP_I2C = 6'd28, OP_I2S = 6'd29, OP_NEG = 6'd30, OP_LDREF = 6'd31,
        OP_STREF = 6'd32, OP_HALT = 6'd36
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_WRITE, S_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch input item
        logic rd_issue;   // issue stack/local reads
        logic exec;       // evaluate the instruction
        logic mul_step;   // accumulate partial products
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic commit;     // write stack/locals, update pointers
        logic out_load;   // load result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic mul_done;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== sv/svie_ctrl.sv =====
// Controller state machine of the stack machine executor.
// Depends on svie_pkg.
module svie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_valid,
    input  logic              out_stall,
    input  svie_pkg::dp_stat_t stat,
    output svie_pkg::dp_cmd_t  cmd
);
    import svie_pkg::*;

    state_t state_reg, state_next;

    // Accept only while idle
    assign in_stall = (state_reg != S_IDLE);

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (stat.need_mul)      state_next = S_MUL;
                else if (stat.need_div) state_next = S_DIV;
                else                    state_next = S_WRITE;
            end
            S_MUL:   if (stat.mul_done) state_next = S_WRITE;
            S_DIV:   if (stat.div_done) state_next = S_WRITE;
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.capture = in_valid;
            S_READ:  cmd.rd_issue = 1'b1;
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.div_start = stat.need_div;
            end
            S_MUL:   cmd.mul_step = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_WRITE: cmd.commit = 1'b1;
            S_OUT:   cmd.out_load = !out_valid || !out_stall;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== sv/svie_dp.sv =====
// Datapath of the stack machine executor: stack and local memories, ALU,
// multiplier, divider, pointers and result register. Depends on svie_pkg.
module svie_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  svie_pkg::dp_cmd_t       cmd,
    output svie_pkg::dp_stat_t      stat,
    input  logic                    cfg_valid,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic [1:0]              cmd_in,
    input  logic [5:0]              opcode,
    input  logic signed [63:0]      operand,
    input  logic [7:0]              local_index,
    input  logic signed [63:0]      local_value,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [1:0]              status,
    output logic [15:0]             next_pc,
    output logic                    print_valid,
    output logic signed [63:0]      print_value,
    output logic signed [63:0]      return_value,
    output logic [8:0]              stack_depth,
    output logic signed [63:0]      read_value
);
    import svie_pkg::*;

    localparam logic [1:0] WSEL_ALU = 2'd0;
    localparam logic [1:0] WSEL_MUL = 2'd1;
    localparam logic [1:0] WSEL_DIV = 2'd2;

    logic [63:0] stack_mem [STACK_DEPTH];
    logic [63:0] local_mem [LOCALS_MAX];

    logic [8:0]  locals_cnt_reg;
    logic [15:0] prog_len_reg;
    logic [SP_W-1:0] sp_reg;
    logic [15:0] pc_reg;
    logic [1:0]  run_reg;

    logic [1:0]  c_cmd_reg;
    logic [5:0]  c_op_reg;
    logic [63:0] c_arg_reg;
    logic [LA_W-1:0] c_li_reg;
    logic [63:0] c_lv_reg;

    logic [63:0] top_reg, sec_reg, loc_reg;
    logic [63:0] res_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locals_cnt_reg <= '0;
            prog_len_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_LOCALS)
                locals_cnt_reg <= cfg_data[8:0];
            else
                prog_len_reg <= cfg_data;
        end
    end

    // Capture the input item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            c_cmd_reg <= cmd_in;
            c_op_reg  <= opcode;
            c_arg_reg <= operand;
            c_li_reg  <= local_index[LA_W-1:0];
            c_lv_reg  <= local_value;
        end
    end

    // Decoded view
    logic is_exec, running, pc_over;
    logic has1, has2, not_full, loc_ok;
    logic [LA_W-1:0] loc_addr;
    assign is_exec  = (c_cmd_reg == CMD_EXEC);
    assign running  = (run_reg == ST_RUN);
    assign pc_over  = (pc_reg >= prog_len_reg);
    assign has1     = (sp_reg >= SP_W'(1));
    assign has2     = (sp_reg >= SP_W'(2));
    assign not_full = (sp_reg < SP_W'(STACK_DEPTH));
    assign loc_ok   = (c_arg_reg < {55'd0, locals_cnt_reg})
                      && (c_arg_reg < 64'(LOCALS_MAX));
    assign loc_addr = (c_cmd_reg == CMD_EXEC) ? c_arg_reg[LA_W-1:0] : c_li_reg;

    logic [SA_W-1:0] a_top, a_sec;
    assign a_top = SA_W'(sp_reg - SP_W'(1));
    assign a_sec = SA_W'(sp_reg - SP_W'(2));

    // Registered memory reads
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            top_reg <= stack_mem[a_top];
            sec_reg <= stack_mem[a_sec];
            loc_reg <= local_mem[loc_addr];
        end
    end

    logic do_ex;
    assign do_ex = is_exec && running && !pc_over;

    // Multiplier: three 32x32 partial products, one a cycle
    logic [1:0]  mul_cnt_reg;
    logic [63:0] mul_acc_reg;
    logic [31:0] m_a, m_b;
    logic [63:0] m_p;
    always_comb
    begin
        m_a = mul_cnt_reg[1] ? sec_reg[63:32] : sec_reg[31:0];
        m_b = mul_cnt_reg[0] ? top_reg[63:32] : top_reg[31:0];
        m_p = 64'(m_a) * 64'(m_b);
    end
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            mul_cnt_reg <= '0;
            mul_acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            mul_cnt_reg <= mul_cnt_reg + 2'd1;
            case (mul_cnt_reg)
                2'd0:    mul_acc_reg <= mul_acc_reg + m_p;
                2'd1,
                2'd2:    mul_acc_reg <= mul_acc_reg + {m_p[31:0], 32'd0};
                default: mul_acc_reg <= mul_acc_reg;
            endcase
        end
    end

    // Restoring divider on magnitudes, one quotient bit a cycle
    logic [6:0]  div_cnt_reg;
    logic [63:0] div_q_reg, div_d_reg;
    logic [64:0] div_r_reg;
    logic        div_neg_reg;
    logic [64:0] div_trial;
    assign div_trial = {div_r_reg[63:0], div_q_reg[63]} - {1'b0, div_d_reg};
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
            div_q_reg   <= sec_reg[63] ? (64'd0 - sec_reg) : sec_reg;
            div_d_reg   <= top_reg[63] ? (64'd0 - top_reg) : top_reg;
            div_r_reg   <= '0;
            div_neg_reg <= sec_reg[63] ^ top_reg[63];
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 7'd1;
            if (!div_trial[64])
            begin
                div_r_reg <= div_trial;
                div_q_reg <= {div_q_reg[62:0], 1'b1};
            end
            else
            begin
                div_r_reg <= {div_r_reg[63:0], div_q_reg[63]};
                div_q_reg <= {div_q_reg[62:0], 1'b0};
            end
        end
    end

    logic op_mul, op_div;
    assign op_mul = do_ex && (c_op_reg == OP_MUL) && has2;
    assign op_div = do_ex && (c_op_reg == OP_DIV) && has2 && (top_reg != 64'd0);
    assign stat.need_mul = op_mul;
    assign stat.need_div = op_div;
    assign stat.mul_done = (mul_cnt_reg == 2'd2);
    assign stat.div_done = (div_cnt_reg == 7'(DIV_CYCLES - 1));

    // Evaluate the instruction: new top value plus pointer/pc/state effects
    logic [5:0]  sh;
    logic        lt_ab, lt_ba, take;
    logic [63:0] alu;
    assign sh    = top_reg[5:0];
    assign lt_ab = (sec_reg ^ 64'h8000000000000000) < (top_reg ^ 64'h8000000000000000);
    assign lt_ba = (top_reg ^ 64'h8000000000000000) < (sec_reg ^ 64'h8000000000000000);

    always_comb
    begin
        alu  = top_reg;
        take = 1'b0;
        case (c_op_reg)
            OP_ADD:  alu = sec_reg + top_reg;
            OP_SUB:  alu = sec_reg - top_reg;
            OP_AND:  alu = sec_reg & top_reg;
            OP_OR:   alu = sec_reg | top_reg;
            OP_XOR:  alu = sec_reg ^ top_reg;
            OP_SHL:  alu = sec_reg << sh;
            OP_SHR:  alu = 64'($signed(sec_reg) >>> sh);
            OP_USHR: alu = sec_reg >> sh;
            OP_I2L:  alu = {{32{top_reg[31]}}, top_reg[31:0]};
            OP_I2B:  alu = {{56{top_reg[7]}}, top_reg[7:0]};
            OP_I2C:  alu = {48'd0, top_reg[15:0]};
            OP_I2S:  alu = {{48{top_reg[15]}}, top_reg[15:0]};
            OP_NEG:  alu = 64'd0 - top_reg;
            OP_IFEQ: take = (sec_reg == top_reg);
            OP_IFNE: take = (sec_reg != top_reg);
            OP_IFLT: take = lt_ab;
            OP_IFLE: take = !lt_ba;
            OP_IFGT: take = lt_ba;
            OP_IFGE: take = !lt_ab;
            default: alu = top_reg;
        endcase
    end

    // Register the write-back plan at the end of the execute state
    logic            wr1_reg, wr2_reg, lw_reg, pr_reg, alu_res_reg;
    logic [SA_W-1:0] wa1_reg, wa2_reg;
    logic [63:0]     wd2_reg, prv_reg;
    logic [SP_W-1:0] sp_new_reg;
    logic [15:0]     pc_new_reg;
    logic [1:0]      run_new_reg;
    logic [63:0]     rd_reg;
    logic [1:0]      wsel_reg;

    logic [15:0] pc_inc, tgt;
    assign pc_inc = pc_reg + 16'd1;
    assign tgt = (c_arg_reg >= {48'd0, prog_len_reg}) ? prog_len_reg : c_arg_reg[15:0];

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            wr1_reg     <= 1'b0;
            wr2_reg     <= 1'b0;
            lw_reg      <= 1'b0;
            pr_reg      <= 1'b0;
            alu_res_reg <= 1'b0;
            wa1_reg     <= a_sec;
            wa2_reg     <= a_top;
            wd2_reg     <= top_reg;
            prv_reg     <= 64'd0;
            res_reg     <= alu;
            wsel_reg    <= WSEL_ALU;
            sp_new_reg  <= sp_reg;
            pc_new_reg  <= pc_reg;
            run_new_reg <= run_reg;
            rd_reg      <= 64'd0;
            case (c_cmd_reg)
                CMD_WRITE: lw_reg <= 1'b1;
                CMD_READ:  rd_reg <= loc_reg;
                CMD_START:
                begin
                    sp_new_reg  <= '0;
                    pc_new_reg  <= '0;
                    run_new_reg <= (prog_len_reg == 16'd0) ? ST_END : ST_RUN;
                end
                default:
                begin
                    if (running && pc_over)
                        run_new_reg <= ST_END;
                    else if (running)
                    begin
                        pc_new_reg <= pc_inc;
                        run_new_reg <= (pc_inc >= prog_len_reg) ? ST_END : ST_RUN;
                        case (c_op_reg) inside
                            OP_PUSH:
                                if (not_full)
                                begin
                                    wr1_reg <= 1'b1;
                                    wa1_reg <= SA_W'(sp_reg);
                                    res_reg <= c_arg_reg;
                                    sp_new_reg <= sp_reg + SP_W'(1);
                                end
                            OP_ADD, OP_SUB, OP_MUL, [OP_AND:OP_USHR]:
                                if (has2)
                                begin
                                    wr1_reg <= 1'b1;
                                    wsel_reg <= (c_op_reg == OP_MUL) ? WSEL_MUL : WSEL_ALU;
                                    sp_new_reg <= sp_reg - SP_W'(1);
                                end
                            OP_DIV:
                                if (has2)
                                begin
                                    sp_new_reg <= sp_reg - SP_W'(1);
                                    if (top_reg == 64'd0)
                                        run_new_reg <= ST_FAULT;
                                    else
                                    begin
                                        wr1_reg <= 1'b1;
                                        wsel_reg <= WSEL_DIV;
                                    end
                                end
                            OP_EMIT:
                                if (has1)
                                begin
                                    pr_reg <= 1'b1;
                                    prv_reg <= top_reg;
                                    sp_new_reg <= sp_reg - SP_W'(1);
                                end
                            OP_SWAP:
                                if (has2)
                                begin
                                    wr1_reg <= 1'b1;
                                    wr2_reg <= 1'b1;
                                    res_reg <= top_reg;
                                    wd2_reg <= sec_reg;
                                end
                            OP_DUP:
                                if (has1 && not_full)
                                begin
                                    wr1_reg <= 1'b1;
                                    wa1_reg <= SA_W'(sp_reg);
                                    res_reg <= top_reg;
                                    sp_new_reg <= sp_reg + SP_W'(1);
                                end
                            OP_LOAD, OP_LDREF:
                                if (not_full && loc_ok)
                                begin
                                    wr1_reg <= 1'b1;
                                    wa1_reg <= SA_W'(sp_reg);
                                    res_reg <= loc_reg;
                                    sp_new_reg <= sp_reg + SP_W'(1);
                                end
                            OP_STLOC, OP_STREF:
                                if (has1 && loc_ok)
                                begin
                                    lw_reg <= 1'b1;
                                    sp_new_reg <= sp_reg - SP_W'(1);
                                end
                            OP_IFEQ, OP_IFNE, [OP_IFLT:OP_IFGE]:
                                if (has2)
                                begin
                                    sp_new_reg <= sp_reg - SP_W'(2);
                                    if (take)
                                    begin
                                        pc_new_reg <= tgt;
                                        run_new_reg <= (tgt >= prog_len_reg) ? ST_END : ST_RUN;
                                    end
                                end
                            OP_GOTO:
                            begin
                                pc_new_reg <= tgt;
                                run_new_reg <= (tgt >= prog_len_reg) ? ST_END : ST_RUN;
                            end
                            [OP_I2L:OP_NEG]:
                                if (has1)
                                begin
                                    wr1_reg <= 1'b1;
                                    wa1_reg <= a_top;
                                end
                            OP_HALT: run_new_reg <= ST_HALT;
                            default: res_reg <= alu;
                        endcase
                    end
                end
            endcase
        end
    end

    // Select the value to write back
    logic [63:0] div_q_signed, wval;
    assign div_q_signed = div_neg_reg ? (64'd0 - div_q_reg) : div_q_reg;
    always_comb
    begin
        case (wsel_reg)
            WSEL_MUL: wval = mul_acc_reg;
            WSEL_DIV: wval = div_q_signed;
            default:  wval = res_reg;
        endcase
    end

    // Memory writes and state commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr1_reg)
            stack_mem[wa1_reg] <= wval;
        else if (cmd.out_load && wr2_reg)
            stack_mem[wa2_reg] <= wd2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && lw_reg)
            local_mem[loc_addr] <= is_exec ? top_reg : c_lv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            pc_reg  <= '0;
            run_reg <= ST_RUN;
        end
        else if (cmd.commit)
        begin
            sp_reg  <= sp_new_reg;
            pc_reg  <= pc_new_reg;
            run_reg <= run_new_reg;
        end
    end

    // Top of stack after commit: captured in the write state for the output state
    logic [63:0] top_now_reg;
    logic [SA_W-1:0] a_top_new;
    assign a_top_new = SA_W'(sp_new_reg - SP_W'(1));
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            top_now_reg <= (wr1_reg && wa1_reg == a_top_new) ? wval :
                           (wr2_reg && wa2_reg == a_top_new) ? wd2_reg :
                           stack_mem[a_top_new];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status       <= run_reg;
            next_pc      <= pc_reg;
            print_valid  <= pr_reg;
            print_value  <= prv_reg;
            return_value <= (run_reg == ST_FAULT || sp_reg == '0) ? 64'd0 : top_now_reg;
            stack_depth  <= 9'(sp_reg);
            read_value   <= rd_reg;
        end
    end

endmodule

// ===== sv/stack_vm_instruction_executor_unit.sv =====
// Stack machine instruction executor: one command in, one result out.
// Channels: in (valid/stall) carries cmd, opcode, operand, local_index and
// local_value; out (valid/stall) carries status, next_pc, print data,
// return_value, stack_depth and read_value. cfg (valid/ready) writes
// locals_count (index 0) and program_length (index 1); always ready.
// Each command passes through read, execute, write and output states;
// multiply adds a multiply state (three 32x32 partial products on one
// multiplier) and divide a divide state (restoring divider, one quotient bit
// a cycle). One item at a time: the next item is taken the cycle after its
// result is loaded.
// Reset clears stack pointer, program counter, run state, configuration and
// out_valid; stack and local memories hold nothing defined until written.
// A stalled result holds in the output register and the block stays busy
// until it can be loaded.
// Depends on svie_pkg, svie_ctrl, svie_dp.
module stack_vm_instruction_executor_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [5:0]         opcode,
    input  logic signed [63:0] operand,
    input  logic [7:0]         local_index,
    input  logic signed [63:0] local_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [15:0]        next_pc,
    output logic               print_valid,
    output logic signed [63:0] print_value,
    output logic signed [63:0] return_value,
    output logic [8:0]         stack_depth,
    output logic signed [63:0] read_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import svie_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    assign cfg_ready = 1'b1;

    svie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dstat),
        .cmd       (dcmd)
    );

    svie_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dcmd),
        .stat         (dstat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index[0]),
        .cfg_data     (cfg_data),
        .cmd_in       (cmd),
        .opcode       (opcode),
        .operand      (operand),
        .local_index  (local_index),
        .local_value  (local_value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .next_pc      (next_pc),
        .print_valid  (print_valid),
        .print_value  (print_value),
        .return_value (return_value),
        .stack_depth  (stack_depth),
        .read_value   (read_value)
    );

endmodule

// ===== sv/svie_checker.sv =====
// Port-level checks for the stack machine executor, bound to the top level.
// Depends on svie_pkg.
module svie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        print_valid,
    input logic [8:0]  stack_depth,
    input logic signed [63:0] return_value
);
    import svie_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result changed");

    // Busy after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // Empty stack reports zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stack_depth == 9'd0 |-> return_value == 64'sd0)
        else $error("empty stack with non-zero top");

    // A faulted result reports zero top
    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FAULT |-> return_value == 64'sd0)
        else $error("faulted result with non-zero top");

    // A printed value only comes from a running or just-ended program
    a_print: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && print_valid |-> (status == ST_RUN || status == ST_END))
        else $error("print reported while halted or faulted");

endmodule

bind stack_vm_instruction_executor_unit svie_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .print_valid(print_valid), .stack_depth(stack_depth),
    .return_value(return_value)
);
